@@ design/lbmt_pkg.sv @@
// Shared types and constants for the learning bridge MAC table.
// No dependencies; every other design file uses this package.
package lbmt_pkg;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 5;
  localparam int AGE_W  = 16;
  localparam int CNT_W  = 7;

  localparam logic [MAC_W-1:0] BCAST_MAC   = {MAC_W{1'b1}};
  localparam logic [AGE_W-1:0] AGE_MAX     = {AGE_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [AGE_W-1:0] AGING_RESET = 16'd300;

  // request operation codes
  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // request held for the whole table walk
  typedef struct packed {
    op_t               op;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
  } req_t;

  // walk token passed from cell to cell
  typedef struct packed {
    logic              active;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
    logic              src_found;
    logic              free_found;
    logic [CNT_W-1:0]  evict_cnt;
  } token_t;

  // insert of a newly learned source
  typedef struct packed {
    logic              en;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } ins_t;

  // finished result
  typedef struct packed {
    logic              flood;
    logic [PORT_W-1:0] out_port;
    logic [PORT_W-1:0] excluded_port;
    logic              dst_hit;
    logic              learned_new;
    logic              table_full;
    logic [CNT_W-1:0]  evicted_count;
  } res_t;

endpackage

@@ design/lbmt_req_if.sv @@
// Request channel of the MAC table: valid/ready plus frame or tick fields.
// Depends on lbmt_pkg for field widths.
interface lbmt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [lbmt_pkg::MAC_W-1:0]    src_mac;
  logic [lbmt_pkg::MAC_W-1:0]    dst_mac;
  logic [lbmt_pkg::PORT_W-1:0]   in_port;

  modport source (output valid, operation, src_mac, dst_mac, in_port, input ready);
  modport sink   (input valid, operation, src_mac, dst_mac, in_port, output ready);
endinterface

@@ design/lbmt_res_if.sv @@
// Result channel of the MAC table: valid/ready plus forwarding result fields.
// Depends on lbmt_pkg for field widths.
interface lbmt_res_if;
  logic                          valid;
  logic                          ready;
  logic                          flood;
  logic [lbmt_pkg::PORT_W-1:0]   out_port;
  logic [lbmt_pkg::PORT_W-1:0]   excluded_port;
  logic                          dst_hit;
  logic                          learned_new;
  logic                          table_full;
  logic [lbmt_pkg::CNT_W-1:0]    evicted_count;

  modport source (output valid, flood, out_port, excluded_port, dst_hit, learned_new,
                  table_full, evicted_count, input ready);
  modport sink   (input valid, flood, out_port, excluded_port, dst_hit, learned_new,
                  table_full, evicted_count, output ready);
endinterface

@@ design/learning_bridge_mac_table_top.sv @@
// Self-learning bridge forwarding table with aging. Each request (a frame or an aging
// tick) walks a row of TABLE_ENTRIES cells, one cell per cycle, carrying a small token
// that collects the destination hit, source match, lowest free slot and eviction count;
// a new source is written into its slot as the token leaves the last cell. One request
// is in the table at a time; the next is accepted once the last result has moved
// into the output register. A finished result waits in the output register while
// the next request is already walking.
// Depends on lbmt_pkg, lbmt_req_if, lbmt_res_if, lbmt_cell and lbmt_ctrl.
module learning_bridge_mac_table_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lbmt_pkg::AGE_W-1:0]  cfg_wdata,
  lbmt_req_if.sink                    req,
  lbmt_res_if.source                  res
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [lbmt_pkg::AGE_W-1:0]  aging_time;
  lbmt_pkg::req_t              req_q;
  lbmt_pkg::ins_t              ins;
  logic [IDX_W-1:0]            ins_idx;
  lbmt_pkg::token_t            tok [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]            idx [TABLE_ENTRIES+1];

  // aging time register
  always_ff @(posedge clk) begin
    if (rst) begin
      aging_time <= lbmt_pkg::AGING_RESET;
    end else if (cfg_we) begin
      aging_time <= cfg_wdata;
    end
  end

  assign idx[0] = '0;

  lbmt_ctrl #(.IDX_W(IDX_W)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .req_q     (req_q),
    .tok_first (tok[0]),
    .tok_last  (tok[TABLE_ENTRIES]),
    .idx_last  (idx[TABLE_ENTRIES]),
    .ins       (ins),
    .ins_idx   (ins_idx)
  );

  // row of table cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lbmt_cell #(.IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .aging_time (aging_time),
      .req        (req_q),
      .tok_in     (tok[i]),
      .idx_in     (idx[i]),
      .ins        (ins),
      .ins_idx    (ins_idx),
      .tok_out    (tok[i+1]),
      .idx_out    (idx[i+1])
    );
  end

endmodule

@@ design/lbmt_cell.sv @@
// One table entry of the MAC table chain plus its stage of the walk token.
// Depends on lbmt_pkg.
module lbmt_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lbmt_pkg::AGE_W-1:0]   aging_time,
  input  lbmt_pkg::req_t               req,
  input  lbmt_pkg::token_t             tok_in,
  input  logic [IDX_W-1:0]             idx_in,
  input  lbmt_pkg::ins_t               ins,
  input  logic [IDX_W-1:0]             ins_idx,
  output lbmt_pkg::token_t             tok_out,
  output logic [IDX_W-1:0]             idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                         valid;
  logic [lbmt_pkg::MAC_W-1:0]   mac;
  logic [lbmt_pkg::PORT_W-1:0]  port;
  logic [lbmt_pkg::AGE_W-1:0]   age;

  logic                         is_frame;
  logic                         is_tick;
  logic                         hit_here;
  logic                         src_here;
  logic                         free_here;
  logic                         evict_here;
  logic                         ins_here;
  logic [lbmt_pkg::AGE_W-1:0]   age_inc;

  // match, free slot and aging decisions for the token now at this cell
  always_comb begin
    is_frame   = tok_in.active && (req.op == lbmt_pkg::OP_FRAME);
    is_tick    = tok_in.active && (req.op == lbmt_pkg::OP_TICK);
    hit_here   = is_frame && valid && !tok_in.dst_hit && (mac == req.dst_mac) &&
                 (req.dst_mac != lbmt_pkg::BCAST_MAC);
    src_here   = is_frame && valid && (mac == req.src_mac);
    free_here  = is_frame && !valid && !tok_in.free_found;
    age_inc    = (age < lbmt_pkg::AGE_MAX) ? age + 1'b1 : age;
    evict_here = is_tick && valid && (age_inc >= aging_time);
    ins_here   = ins.en && (ins_idx == MY_IDX);
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins_here) begin
      valid <= 1'b1;
    end else if (evict_here) begin
      valid <= 1'b0;
    end
    if (ins_here) begin
      mac  <= ins.mac;
      port <= ins.port;
      age  <= '0;
    end else if (is_tick && valid) begin
      age <= age_inc;
    end else if (src_here) begin
      age <= '0;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.dst_hit    <= tok_in.dst_hit || hit_here;
    tok_out.dst_port   <= hit_here ? port : tok_in.dst_port;
    tok_out.src_found  <= tok_in.src_found || src_here;
    tok_out.free_found <= tok_in.free_found || free_here;
    tok_out.evict_cnt  <= (evict_here && (tok_in.evict_cnt < lbmt_pkg::CNT_MAX)) ?
                          tok_in.evict_cnt + 1'b1 : tok_in.evict_cnt;
    idx_out            <= free_here ? MY_IDX : idx_in;
  end

endmodule

@@ design/lbmt_ctrl.sv @@
// Request intake, walk launch, result finish and output register of the MAC table.
// Depends on lbmt_pkg and the lbmt_req_if / lbmt_res_if interfaces.
module lbmt_ctrl #(
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  lbmt_req_if.sink          req,
  lbmt_res_if.source        res,
  output lbmt_pkg::req_t    req_q,
  output lbmt_pkg::token_t  tok_first,
  input  lbmt_pkg::token_t  tok_last,
  input  logic [IDX_W-1:0]  idx_last,
  output lbmt_pkg::ins_t    ins,
  output logic [IDX_W-1:0]  ins_idx
);

  logic            busy;
  logic            fin_valid;
  lbmt_pkg::res_t  fin;
  lbmt_pkg::res_t  fin_next;
  logic            accept;
  logic            move;
  logic            is_frame;

  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign move      = fin_valid && (!res.valid || res.ready);
  assign is_frame  = req_q.op == lbmt_pkg::OP_FRAME;

  // learn insert when the token leaves the last cell
  always_comb begin
    ins.en   = tok_last.active && is_frame && !tok_last.src_found && tok_last.free_found;
    ins.mac  = req_q.src_mac;
    ins.port = req_q.in_port;
    ins_idx  = idx_last;
  end

  // result of the finished walk
  always_comb begin
    fin_next = '0;
    if (is_frame) begin
      fin_next.dst_hit     = tok_last.dst_hit;
      fin_next.flood       = !tok_last.dst_hit;
      fin_next.out_port    = tok_last.dst_hit ? tok_last.dst_port : '0;
      fin_next.excluded_port = tok_last.dst_hit ? '0 : req_q.in_port;
      fin_next.learned_new = !tok_last.src_found && tok_last.free_found;
      fin_next.table_full  = !tok_last.src_found && !tok_last.free_found;
    end else begin
      fin_next.evicted_count = tok_last.evict_cnt;
    end
  end

  // control flags and the fresh token launched into the first cell
  always_ff @(posedge clk) begin
    tok_first.dst_hit    <= 1'b0;
    tok_first.dst_port   <= '0;
    tok_first.src_found  <= 1'b0;
    tok_first.free_found <= 1'b0;
    tok_first.evict_cnt  <= '0;
    if (rst) begin
      busy             <= 1'b0;
      fin_valid        <= 1'b0;
      tok_first.active <= 1'b0;
      res.valid        <= 1'b0;
    end else begin
      tok_first.active <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (tok_last.active) begin
        fin_valid <= 1'b1;
      end else if (move) begin
        fin_valid <= 1'b0;
      end
      if (move) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.op      <= lbmt_pkg::op_t'(req.operation);
      req_q.src_mac <= req.src_mac;
      req_q.dst_mac <= req.dst_mac;
      req_q.in_port <= req.in_port;
    end
    if (tok_last.active) begin
      fin <= fin_next;
    end
    if (move) begin
      res.flood         <= fin.flood;
      res.out_port      <= fin.out_port;
      res.excluded_port <= fin.excluded_port;
      res.dst_hit       <= fin.dst_hit;
      res.learned_new   <= fin.learned_new;
      res.table_full    <= fin.table_full;
      res.evicted_count <= fin.evicted_count;
    end
  end

endmodule
